### hdl/w8a8_pkg.sv
`timescale 1ns / 1ps

package w8a8_pkg;

    // Block geometry and fixed-point format
    localparam int BLOCK_ELEMS = 16;
    localparam int FRAC_BITS   = 24;

    // Widths of the block term datapath
    localparam int DOT_W  = 21;                 // |dot| <= 16 * 255 * 128
    localparam int PWS_W  = 32 + DOT_W;         // weight_scale * dot
    localparam int PWO_W  = 32 + 12;            // weight_offset * act_sum
    localparam int TERM_W = PWS_W + 1;          // difference of the two

    // Term queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One queued block term
    typedef struct packed {
        logic signed [TERM_W-1:0] term;
        logic                     last;
    } t_qent;

endpackage

### hdl/w8a8_front.sv
`timescale 1ns / 1ps

module w8a8_front import w8a8_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [63:0]         i_weights_low,
    input  logic [63:0]         i_weights_high,
    input  logic [63:0]         i_acts_low,
    input  logic [63:0]         i_acts_high,
    input  logic signed [31:0]  i_weight_scale,
    input  logic signed [31:0]  i_weight_offset,
    input  logic signed [11:0]  i_act_sum,
    input  logic                i_last_block,
    input  logic                i_q_full,
    output logic                o_q_push,
    output t_qent               o_q_data
);

    logic [8*BLOCK_ELEMS-1:0]   w_wts;
    logic [8*BLOCK_ELEMS-1:0]   w_acts;
    logic signed [16:0]         w_prod [BLOCK_ELEMS];
    logic signed [17:0]         w_s1   [BLOCK_ELEMS/2];
    logic signed [18:0]         w_s2   [BLOCK_ELEMS/4];
    logic signed [19:0]         w_s3   [BLOCK_ELEMS/8];
    logic signed [DOT_W-1:0]    w_dot;

    logic                       r_v1;
    logic signed [DOT_W-1:0]    r_dot;
    logic signed [31:0]         r_ws1;
    logic signed [31:0]         r_wo1;
    logic signed [11:0]         r_as1;
    logic                       r_last1;

    logic                       r_v2;
    logic signed [PWS_W-1:0]    r_p_ws;
    logic signed [PWO_W-1:0]    r_p_wo;
    logic                       r_last2;

    logic                       w_adv1;
    logic                       w_adv2;
    logic                       w_load1;
    logic                       w_accept;

    assign w_wts  = {i_weights_high, i_weights_low};
    assign w_acts = {i_acts_high, i_acts_low};

    // Lane products: unsigned weight times signed activation
    always_comb begin
        for (int i = 0; i < BLOCK_ELEMS; i++) begin
            w_prod[i] = $signed({1'b0, w_wts[8*i +: 8]}) * $signed(w_acts[8*i +: 8]);
        end
    end

    // Adder tree over the lanes
    always_comb begin
        for (int i = 0; i < BLOCK_ELEMS/2; i++) begin
            w_s1[i] = 18'(w_prod[2*i]) + 18'(w_prod[2*i+1]);
        end
        for (int i = 0; i < BLOCK_ELEMS/4; i++) begin
            w_s2[i] = 19'(w_s1[2*i]) + 19'(w_s1[2*i+1]);
        end
        for (int i = 0; i < BLOCK_ELEMS/8; i++) begin
            w_s3[i] = 20'(w_s2[2*i]) + 20'(w_s2[2*i+1]);
        end
        w_dot = DOT_W'(w_s3[0]) + DOT_W'(w_s3[1]);
    end

    // Pipeline flow: stage 2 drains into the queue, stage 1 into stage 2
    assign o_q_push   = r_v2 && !i_q_full;
    assign w_adv2     = !r_v2 || o_q_push;
    assign w_load1    = r_v1 && w_adv2;
    assign w_adv1     = !r_v1 || w_load1;
    assign o_in_stall = !w_adv1;
    assign w_accept   = i_in_valid && w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_in_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage 1: dot product and block coefficients
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dot   <= w_dot;
            r_ws1   <= i_weight_scale;
            r_wo1   <= i_weight_offset;
            r_as1   <= i_act_sum;
            r_last1 <= i_last_block;
        end
    end

    // Stage 2: scale and offset products
    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_p_ws  <= PWS_W'(r_ws1) * PWS_W'(r_dot);
            r_p_wo  <= PWO_W'(r_wo1) * PWO_W'(r_as1);
            r_last2 <= r_last1;
        end
    end

    // Block term into the queue
    assign o_q_data.term = TERM_W'(r_p_ws) - TERM_W'(r_p_wo);
    assign o_q_data.last = r_last2;

endmodule

### hdl/w8a8_fifo.sv
`timescale 1ns / 1ps

module w8a8_fifo import w8a8_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qent   i_data,
    input  logic    i_pop,
    output t_qent   o_data,
    output logic    o_full,
    output logic    o_empty
);

    t_qent              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr_ptr;
    logic [Q_AW-1:0]    r_rd_ptr;
    logic [Q_AW:0]      r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/w8a8_back.sv
`timescale 1ns / 1ps

module w8a8_back import w8a8_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  t_qent               i_q_data,
    output logic                o_q_pop,
    input  logic signed [31:0]  i_act_scale,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [63:0]  o_dot_value
);

    localparam logic [2:0] ST_ACC = 3'd0;
    localparam logic [2:0] ST_ABS = 3'd1;
    localparam logic [2:0] ST_MLO = 3'd2;
    localparam logic [2:0] ST_MHI = 3'd3;
    localparam logic [2:0] ST_ADD = 3'd4;
    localparam logic [2:0] ST_RND = 3'd5;
    localparam logic [2:0] ST_OUT = 3'd6;

    localparam logic [63:0] POS_LIM = {1'b0, {63{1'b1}}};
    localparam logic [63:0] NEG_LIM = {1'b1, {63{1'b0}}};

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic signed [63:0]     r_acc;
    logic signed [63:0]     r_fin;
    logic                   r_neg;
    logic [63:0]            r_mx;
    logic [31:0]            r_my;
    logic [63:0]            r_pl;
    logic [63:0]            r_ph;
    logic [95:0]            r_full;
    logic [63:0]            r_q;
    logic                   r_ov;
    logic signed [63:0]     r_dot;

    logic signed [64:0]     w_sum;
    logic signed [63:0]     w_sat;
    logic [31:0]            w_mop;
    logic [63:0]            w_prod;
    logic [95:0]            w_rnd;
    logic [95:0]            w_qw;
    logic [63:0]            w_lim;
    logic                   w_out_free;

    assign o_q_pop    = (r_state == ST_ACC) && !i_q_empty;
    assign w_out_free = !r_ov || !i_out_stall;

    // Saturating accumulate of the block term
    assign w_sum = 65'(r_acc) + 65'(i_q_data.term);
    always_comb begin
        if (w_sum[64] != w_sum[63]) begin
            w_sat = w_sum[64] ? NEG_LIM : POS_LIM;
        end else begin
            w_sat = w_sum[63:0];
        end
    end

    // Shared 32x32 multiplier: low half, then high half of the magnitude
    assign w_mop  = (r_state == ST_MLO) ? r_mx[31:0] : r_mx[63:32];
    assign w_prod = w_mop * r_my;

    // Round to nearest, ties away from zero, then clamp the magnitude
    assign w_rnd = r_full + (96'd1 << (FRAC_BITS - 1));
    assign w_qw  = w_rnd >> FRAC_BITS;
    assign w_lim = r_neg ? NEG_LIM : POS_LIM;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC: begin
                if (o_q_pop && i_q_data.last) begin
                    n_state = ST_ABS;
                end
            end
            ST_ABS: n_state = ST_MLO;
            ST_MLO: n_state = ST_MHI;
            ST_MHI: n_state = ST_ADD;
            ST_ADD: n_state = ST_RND;
            ST_RND: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    // Control state: sequencer, accumulator, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_acc   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_acc <= i_q_data.last ? 64'sd0 : w_sat;
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Result datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_ACC: begin
                if (o_q_pop) begin
                    r_fin <= w_sat;
                end
            end
            ST_ABS: begin
                r_neg <= r_fin[63] ^ i_act_scale[31];
                r_mx  <= r_fin[63] ? (64'd0 - r_fin) : r_fin;
                r_my  <= i_act_scale[31] ? (32'd0 - i_act_scale) : i_act_scale;
            end
            ST_MLO: r_pl <= w_prod;
            ST_MHI: r_ph <= w_prod;
            ST_ADD: r_full <= {32'd0, r_pl} + {r_ph, 32'd0};
            ST_RND: begin
                if ((|w_qw[95:64]) || (w_qw[63:0] > w_lim)) begin
                    r_q <= w_lim;
                end else begin
                    r_q <= w_qw[63:0];
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_dot <= r_neg ? (64'sd0 - r_q) : r_q;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_dot_value = r_dot;

endmodule

### hdl/w8a8_block_dot_product.sv
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// input     i_in_valid / o_in_stall     i_weights_low .. i_last_block
// output    o_out_valid / i_out_stall   o_dot_value
// config    i_cfg_we                    i_cfg_data (act_scale)
//
// Front: two pipeline stages (dot product, then scale/offset products) feed a
// 4-entry term queue; one block is taken per cycle while the queue has room.
// Back: a non-last block leaves the queue and is accumulated; a last block
// holds the back end while the shared 32x32 multiplier forms the 64x32 result
// product in two passes, plus round and clamp.
// Reset (synchronous, active low) clears the accumulator, queue and valids and
// sets act_scale to 1.0. Either side may stall without losing a transfer.

module w8a8_block_dot_product import w8a8_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic signed [31:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [63:0]         i_weights_low,
    input  logic [63:0]         i_weights_high,
    input  logic [63:0]         i_acts_low,
    input  logic [63:0]         i_acts_high,
    input  logic signed [31:0]  i_weight_scale,
    input  logic signed [31:0]  i_weight_offset,
    input  logic signed [11:0]  i_act_sum,
    input  logic                i_last_block,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [63:0]  o_dot_value
);

    logic signed [31:0] r_act_scale;
    logic               w_q_push;
    logic               w_q_pop;
    logic               w_q_full;
    logic               w_q_empty;
    t_qent              w_q_wdata;
    t_qent              w_q_rdata;

    // Activation scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_scale <= 32'sd1 <<< FRAC_BITS;
        end else if (i_cfg_we) begin
            r_act_scale <= i_cfg_data;
        end
    end

    w8a8_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_weights_low   (i_weights_low),
        .i_weights_high  (i_weights_high),
        .i_acts_low      (i_acts_low),
        .i_acts_high     (i_acts_high),
        .i_weight_scale  (i_weight_scale),
        .i_weight_offset (i_weight_offset),
        .i_act_sum       (i_act_sum),
        .i_last_block    (i_last_block),
        .i_q_full        (w_q_full),
        .o_q_push        (w_q_push),
        .o_q_data        (w_q_wdata)
    );

    w8a8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    w8a8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_rdata),
        .o_q_pop     (w_q_pop),
        .i_act_scale (r_act_scale),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dot_value (o_dot_value)
    );

endmodule

### tb/w8a8_dot_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the act_scale port, predicts each dot_value and
// compares it with what the block delivers.
module w8a8_dot_checker import w8a8_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [31:0] i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [63:0]        i_weights_low,
    input  logic [63:0]        i_weights_high,
    input  logic [63:0]        i_acts_low,
    input  logic [63:0]        i_acts_high,
    input  logic signed [31:0] i_weight_scale,
    input  logic signed [31:0] i_weight_offset,
    input  logic signed [11:0] i_act_sum,
    input  logic               i_last_block,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [63:0] i_dot_value,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
    localparam int                 REPORT_LIMIT = 10;

    logic signed [31:0] act_scale;
    logic signed [63:0] running_sum;
    logic signed [63:0] dot_expected[$];
    int                 mismatches = 0;

    // Exact block term: weight_scale * dot - weight_offset * act_sum
    function automatic logic signed [63:0] block_term(
        input logic [63:0]        w_lo,
        input logic [63:0]        w_hi,
        input logic [63:0]        a_lo,
        input logic [63:0]        a_hi,
        input logic signed [31:0] w_scale,
        input logic signed [31:0] w_offset,
        input logic signed [11:0] a_sum
    );
        longint             dot;
        logic [7:0]         wb;
        logic signed [7:0]  ab;
        dot = 0;
        for (int k = 0; k < BLOCK_ELEMS; k++) begin
            wb  = (k < 8) ? w_lo[8*k +: 8] : w_hi[8*(k-8) +: 8];
            ab  = (k < 8) ? a_lo[8*k +: 8] : a_hi[8*(k-8) +: 8];
            dot += longint'(wb) * longint'(ab);
        end
        return longint'(w_scale) * dot - longint'(w_offset) * longint'(a_sum);
    endfunction

    // Accumulate with clamping at the 64-bit limits
    function automatic logic signed [63:0] accumulate(
        input logic signed [63:0] acc,
        input logic signed [63:0] term
    );
        logic signed [64:0] s;
        s = 65'(acc) + 65'(term);
        if (s[64] != s[63])
            return s[64] ? SUM_MIN : SUM_MAX;
        return s[63:0];
    endfunction

    // act_scale * sum, magnitude rounded half away from zero, then clamped
    function automatic logic signed [63:0] scale_result(
        input logic signed [63:0] acc,
        input logic signed [31:0] scale
    );
        logic signed [96:0] xs;
        logic signed [96:0] ys;
        logic signed [96:0] p;
        logic [96:0]        mag;
        logic [96:0]        q;
        xs  = acc;
        ys  = scale;
        p   = xs * ys;
        mag = p[96] ? 97'(-p) : 97'(p);
        q   = (mag + (97'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (p[96]) begin
            if (q > 97'h8000_0000_0000_0000)
                return SUM_MIN;
            return -q[63:0];
        end
        if (q > 97'h7FFF_FFFF_FFFF_FFFF)
            return SUM_MAX;
        return q[63:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [63:0] want;
        if (!i_rst_n) begin
            act_scale   = 32'(1) << FRAC_BITS;
            running_sum = '0;
            dot_expected.delete();
        end else begin
            // result transfer against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (dot_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result transfer: dot_value=%0d", i_dot_value);
                end else begin
                    want = dot_expected.pop_front();
                    if (i_dot_value !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("dot_value mismatch: expected %0d, got %0d",
                                     want, i_dot_value);
                    end
                end
            end
            // input transfer updates the running sum
            if (i_in_valid && !i_in_stall) begin
                running_sum = accumulate(running_sum,
                                         block_term(i_weights_low, i_weights_high,
                                                    i_acts_low, i_acts_high,
                                                    i_weight_scale, i_weight_offset,
                                                    i_act_sum));
                if (i_last_block) begin
                    dot_expected.push_back(scale_result(running_sum, act_scale));
                    running_sum = '0;
                end
            end
            if (i_cfg_we)
                act_scale = i_cfg_data;
        end
        o_pending    <= dot_expected.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top import w8a8_pkg::*; ();

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 48;      // front pipe + full queue of last blocks
    localparam int HOLD_CYCLES   = 300;
    localparam int CLAMP_RUN     = 80;      // enough to clamp the scaled result
    localparam int PHASE_ITEMS   = 30;
    localparam int LAST_PCT      = 20;
    localparam int HOLD_LAST_PCT = 50;      // dense last blocks so the hold backs up

    localparam logic signed [31:0] SCALE_ONE  = 32'(1) << FRAC_BITS;
    localparam logic signed [31:0] SCALE_HALF = 32'(1) << (FRAC_BITS - 1);
    localparam logic signed [31:0] SCALE_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SCALE_MIN  = 32'sh8000_0000;
    localparam logic signed [11:0] ASUM_MAX   = 12'sh7F0;
    localparam logic signed [11:0] ASUM_MIN   = 12'sh800;

    typedef struct {
        logic [63:0]        w_lo;
        logic [63:0]        w_hi;
        logic [63:0]        a_lo;
        logic [63:0]        a_hi;
        logic signed [31:0] w_scale;
        logic signed [31:0] w_offset;
        logic signed [11:0] a_sum;
        logic               last;
    } t_dot_block;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic signed [31:0] i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [63:0]        i_weights_low;
    logic [63:0]        i_weights_high;
    logic [63:0]        i_acts_low;
    logic [63:0]        i_acts_high;
    logic signed [31:0] i_weight_scale;
    logic signed [31:0] i_weight_offset;
    logic signed [11:0] i_act_sum;
    logic               i_last_block;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [63:0] o_dot_value;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit hold_req    = 1'b0;
    bit in_quiet    = 1'b0;
    bit out_quiet   = 1'b0;

    w8a8_block_dot_product dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_weights_low  (i_weights_low),
        .i_weights_high (i_weights_high),
        .i_acts_low     (i_acts_low),
        .i_acts_high    (i_acts_high),
        .i_weight_scale (i_weight_scale),
        .i_weight_offset(i_weight_offset),
        .i_act_sum      (i_act_sum),
        .i_last_block   (i_last_block),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_dot_value    (o_dot_value)
    );

    w8a8_dot_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_weights_low  (i_weights_low),
        .i_weights_high (i_weights_high),
        .i_acts_low     (i_acts_low),
        .i_acts_high    (i_acts_high),
        .i_weight_scale (i_weight_scale),
        .i_weight_offset(i_weight_offset),
        .i_act_sum      (i_act_sum),
        .i_last_block   (i_last_block),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_dot_value    (o_dot_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_scale();
        case ($urandom_range(0, 7))
            0: return SCALE_MAX;
            1: return SCALE_MIN;
            2: return '0;
            3: return $urandom_range(0, 1 << FRAC_BITS);
            4: return 32'(-int'($urandom_range(0, 1 << FRAC_BITS)));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_dot_block make_block(
        input logic [63:0]        w_lo,
        input logic [63:0]        w_hi,
        input logic [63:0]        a_lo,
        input logic [63:0]        a_hi,
        input logic signed [31:0] w_scale,
        input logic signed [31:0] w_offset,
        input logic signed [11:0] a_sum,
        input logic               last
    );
        t_dot_block b;
        b.w_lo     = w_lo;
        b.w_hi     = w_hi;
        b.a_lo     = a_lo;
        b.a_hi     = a_hi;
        b.w_scale  = w_scale;
        b.w_offset = w_offset;
        b.a_sum    = a_sum;
        b.last     = last;
        return b;
    endfunction

    // Block term near the largest of either sign
    function automatic t_dot_block max_term_block(input bit positive, input bit last);
        if (positive)
            return make_block('1, '1, {8{8'h80}}, {8{8'h80}}, SCALE_MIN, SCALE_MAX,
                              ASUM_MIN, last);
        return make_block('1, '1, {8{8'h7F}}, {8{8'h7F}}, SCALE_MIN, SCALE_MAX,
                          ASUM_MAX, last);
    endfunction

    // Block whose term is exactly v
    function automatic t_dot_block small_term_block(input logic signed [7:0] v,
                                                    input bit last);
        return make_block(64'd1, '0, {56'd0, v}, '0, 32'sd1, '0, '0, last);
    endfunction

    function automatic t_dot_block random_block(input int last_pct);
        t_dot_block b;
        b.w_lo = {$urandom(), $urandom()};
        b.w_hi = {$urandom(), $urandom()};
        b.a_lo = {$urandom(), $urandom()};
        b.a_hi = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: begin
                b.w_lo = '1; b.w_hi = '1;
                b.a_lo = {8{8'h7F}}; b.a_hi = {8{8'h7F}};
            end
            1: begin
                b.w_lo = '1; b.w_hi = '1;
                b.a_lo = {8{8'h80}}; b.a_hi = {8{8'h80}};
            end
            2: begin
                b.w_lo = '0; b.w_hi = '0;
            end
            default: ;
        endcase
        b.w_scale  = pick_scale();
        b.w_offset = pick_scale();
        b.a_sum    = 12'(int'($urandom_range(0, 4080)) - 2048);
        b.last     = ($urandom_range(0, 99) < last_pct);
        return b;
    endfunction

    // One input transfer, with an optional gap in front
    task automatic send_block(input t_dot_block b, input bit no_gap);
        int gap;
        gap = (no_gap || in_quiet) ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_weights_low   <= b.w_lo;
        i_weights_high  <= b.w_hi;
        i_acts_low      <= b.a_lo;
        i_acts_high     <= b.a_hi;
        i_weight_scale  <= b.w_scale;
        i_weight_offset <= b.w_offset;
        i_act_sum       <= b.a_sum;
        i_last_block    <= b.last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Wait for every predicted result, then let the pipe empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_act_scale(input logic signed [31:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold on request
    initial begin
        int len;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            len = out_quiet ? 0 : pick_gap();
            if (len > 0) begin
                i_out_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_weights_low   <= '0;
        i_weights_high  <= '0;
        i_acts_low      <= '0;
        i_acts_high     <= '0;
        i_weight_scale  <= '0;
        i_weight_offset <= '0;
        i_act_sum       <= '0;
        i_last_block    <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes at the reset scale of 1.0
        send_block(max_term_block(1'b1, 1'b1), 1'b0);
        send_block(max_term_block(1'b0, 1'b1), 1'b0);
        send_block(make_block('0, '0, '0, '0, '0, '0, '0, 1'b1), 1'b0);
        send_block(make_block('1, '1, {8{8'h7F}}, {8{8'h80}}, SCALE_MAX, SCALE_MAX,
                              ASUM_MAX, 1'b0), 1'b0);
        send_block(make_block('1, '1, {8{8'h80}}, {8{8'h7F}}, SCALE_MIN, SCALE_MIN,
                              ASUM_MIN, 1'b1), 1'b0);
        send_block(make_block('0, '0, '0, '0, '0, SCALE_MIN, ASUM_MIN, 1'b1), 1'b0);
        send_block(make_block('0, '0, '0, '0, '0, SCALE_MAX, ASUM_MAX, 1'b1), 1'b0);
        // act_sum that disagrees with the activations
        send_block(make_block('1, '0, {8{8'h01}}, '0, SCALE_ONE, SCALE_ONE,
                              ASUM_MIN, 1'b1), 1'b0);
        send_block(small_term_block(8'sd1, 1'b1), 1'b0);
        send_block(small_term_block(-8'sd1, 1'b1), 1'b0);

        // rounding ties at a scale of one half
        write_act_scale(SCALE_HALF);
        send_block(small_term_block(8'sd1, 1'b1), 1'b0);
        send_block(small_term_block(-8'sd1, 1'b1), 1'b0);
        send_block(small_term_block(8'sd3, 1'b1), 1'b0);
        send_block(small_term_block(-8'sd3, 1'b1), 1'b0);
        send_block(small_term_block(8'sd1, 1'b0), 1'b0);
        send_block(small_term_block(8'sd4, 1'b1), 1'b0);

        // scaled result clamps at both limits
        write_act_scale(SCALE_MAX);
        repeat (CLAMP_RUN) send_block(max_term_block(1'b1, 1'b0), 1'b1);
        send_block(max_term_block(1'b1, 1'b1), 1'b1);
        repeat (CLAMP_RUN) send_block(max_term_block(1'b0, 1'b0), 1'b1);
        send_block(max_term_block(1'b0, 1'b1), 1'b1);

        // random blocks over several scales
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                1:       write_act_scale('0);
                2:       write_act_scale(-32'sd1);
                3:       write_act_scale(SCALE_MAX);
                4:       write_act_scale(SCALE_MIN);
                5:       write_act_scale(SCALE_ONE);
                default: write_act_scale($urandom());
            endcase
            in_quiet  = (ph == 3);
            out_quiet = (ph == 3);
            // long result-side hold while blocks keep coming
            if (ph == 0)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_block(random_block((ph == 0) ? HOLD_LAST_PCT : LAST_PCT), 1'b0);
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
